FILE: hdl/wvlp_pkg.sv
package wvlp_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Row count limit and the fixed widths that follow from it
  localparam int MAX_BINS = 64;
  localparam int ROW_W    = 6;   // row number, 0..MAX_BINS-1
  localparam int NF_W     = 7;   // n_freq register

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_N_FREQ        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE  = 2'd2;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Per-row control carried alongside the store read
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             real_only;  // center row: real part only
    logic             zero;       // row outside the edge limit
    logic             last;
  } row_ctl_t;

endpackage

FILE: hdl/wvlp_ram.sv
module wvlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/wvlp_addr_gen.sv
module wvlp_addr_gen #(
  parameter int MAX_SAMPLES = wvlp_pkg::DEF_MAX_SAMPLES,
  parameter int IDX_W       = $clog2(MAX_SAMPLES),
  parameter int LEN_W       = IDX_W + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  launch,
  input  logic [LEN_W-1:0]      time_instant,
  input  logic [LEN_W-1:0]      signal_length,
  input  logic [wvlp_pkg::NF_W-1:0] n_freq,
  output logic                  running,
  output logic [IDX_W-1:0]      raddr_a,
  output logic [IDX_W-1:0]      raddr_b,
  output wvlp_pkg::row_ctl_t    ctl
);

  localparam int NF_W  = wvlp_pkg::NF_W;
  localparam int ROW_W = wvlp_pkg::ROW_W;
  // signed working width: covers positions, lags and limits
  localparam int SW    = ((LEN_W > NF_W) ? LEN_W : NF_W) + 2;

  logic [LEN_W-1:0]     len_c;
  logic [NF_W-1:0]      nb_c;
  logic [NF_W-1:0]      half_c;
  logic signed [SW-1:0] pos_c, lenp_c, halfp_c, lim_len_c, lim_half_c, tau_c;
  logic                 hok_c;

  logic                 running_r, running_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [NF_W-1:0]      nb_r, half_r;
  logic signed [SW-1:0] pos_r, tau_r;
  logic                 hok_r;

  logic signed [SW-1:0] halfp_r, lag, mag, lag_e, addr_a, addr_b;
  logic                 lag_pos, use_tau, half_row, use_row, last_row;
  wvlp_pkg::row_ctl_t   ctl_r, ctl_nxt;

  // Column setup: clamp the registers, find the edge limit
  always_comb begin
    len_c      = (signal_length > LEN_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES) : signal_length;
    nb_c       = (n_freq > NF_W'(wvlp_pkg::MAX_BINS)) ? NF_W'(wvlp_pkg::MAX_BINS) : n_freq;
    half_c     = nb_c >> 1;
    pos_c      = $signed(SW'(time_instant)) - SW'(1);
    lenp_c     = $signed(SW'(len_c));
    halfp_c    = $signed(SW'(half_c));
    lim_len_c  = lenp_c - pos_c - SW'(1);
    lim_half_c = halfp_c - SW'(1);
    tau_c      = pos_c;
    if (lim_len_c < tau_c) begin
      tau_c = lim_len_c;
    end
    if (lim_half_c < tau_c) begin
      tau_c = lim_half_c;
    end
    hok_c = (pos_c >= halfp_c) && (pos_c <= lenp_c - halfp_c - SW'(1));
  end

  // Per-row lag, in-bounds test and store addresses
  always_comb begin
    halfp_r  = $signed(SW'(half_r));
    lag_pos  = ({1'b0, row_r, 1'b0} < {1'b0, nb_r});
    lag      = lag_pos ? $signed(SW'(row_r)) : $signed(SW'(row_r)) - $signed(SW'(nb_r));
    mag      = (lag < 0) ? -lag : lag;
    use_tau  = (mag <= tau_r);
    half_row = ({1'b0, row_r} == half_r) && hok_r;
    use_row  = use_tau || half_row;
    lag_e    = use_tau ? lag : halfp_r;
    addr_a   = pos_r + lag_e;
    addr_b   = pos_r - lag_e;
    last_row = ({1'b0, row_r} == nb_r - NF_W'(1));

    ctl_nxt.valid     = running_r;
    ctl_nxt.row       = row_r;
    ctl_nxt.real_only = !use_tau && half_row;
    ctl_nxt.zero      = !use_row;
    ctl_nxt.last      = last_row;

    raddr_a = use_row ? addr_a[IDX_W-1:0] : '0;
    raddr_b = use_row ? addr_b[IDX_W-1:0] : '0;
  end

  // Row sequencer
  always_comb begin
    running_nxt = running_r;
    row_nxt     = row_r;
    if (running_r) begin
      if (last_row) begin
        running_nxt = 1'b0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end else if (launch && (nb_c != '0)) begin
      running_nxt = 1'b1;
      row_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      row_r     <= '0;
      ctl_r     <= '0;
    end else begin
      running_r <= running_nxt;
      row_r     <= row_nxt;
      ctl_r     <= ctl_nxt;
    end
  end

  // Column parameters, held for the whole column
  always_ff @(posedge clk) begin
    if (!running_r && launch) begin
      nb_r   <= nb_c;
      half_r <= half_c;
      pos_r  <= pos_c;
      tau_r  <= tau_c;
      hok_r  <= hok_c;
    end
  end

  assign running = running_r;
  assign ctl     = ctl_r;

  // Row counter never passes the column's row count
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> ({1'b0, row_r} < nb_r))
    else $error("row counter beyond row count");

  // Issuing the final row ends the column
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    running_r && last_row |=> !running_r)
    else $error("sequencer ran past the last row");

  // A row of the column marked for the real part alone cannot be a zero row
  a_center_used: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.valid && ctl_r.real_only |-> !ctl_r.zero)
    else $error("center row flagged both real-only and zero");

endmodule

FILE: hdl/wvlp_mac.sv
module wvlp_mac #(
  parameter int SAMPLE_BITS = wvlp_pkg::DEF_SAMPLE_BITS,
  parameter int OUT_W       = 2 * SAMPLE_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wvlp_pkg::row_ctl_t          ctl,
  input  logic [2*SAMPLE_BITS-1:0]    rdata_a,
  input  logic [2*SAMPLE_BITS-1:0]    rdata_b,
  input  logic                        complex_mode,
  output logic                        pending,
  output logic                        out_valid,
  output logic [wvlp_pkg::ROW_W-1:0]  out_row_index,
  output logic signed [OUT_W-1:0]     out_lag_real,
  output logic signed [OUT_W-1:0]     out_lag_imag,
  output logic                        out_last_row
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [SB-1:0] ra, ia, rb, ib;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  wvlp_pkg::row_ctl_t   ctl2_r;

  logic signed [OUT_W-1:0] re_nxt, im_nxt;
  logic                    out_valid_r;
  logic [wvlp_pkg::ROW_W-1:0] out_row_r;
  logic signed [OUT_W-1:0] out_re_r, out_im_r;
  logic                    out_last_r;

  // Store word is {real, imag}; a is x(p+lag), b is x(p-lag)
  assign ra = rdata_a[PW-1:SB];
  assign ia = rdata_a[SB-1:0];
  assign rb = rdata_b[PW-1:SB];
  assign ib = rdata_b[SB-1:0];

  // Multiply stage
  always_ff @(posedge clk) begin
    p_rr_r <= ra * rb;
    p_ii_r <= ia * ib;
    p_ir_r <= ia * rb;
    p_ri_r <= ra * ib;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl;
    end
  end

  // Combine stage: x(p+lag) * conj(x(p-lag))
  always_comb begin
    re_nxt = OUT_W'(p_rr_r);
    im_nxt = '0;
    if (complex_mode) begin
      re_nxt = OUT_W'(p_rr_r) + OUT_W'(p_ii_r);
      if (!ctl2_r.real_only) begin
        im_nxt = OUT_W'(p_ir_r) - OUT_W'(p_ri_r);
      end
    end
    if (ctl2_r.zero) begin
      re_nxt = '0;
      im_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= ctl2_r.row;
    out_re_r   <= re_nxt;
    out_im_r   <= im_nxt;
    out_last_r <= ctl2_r.last;
  end

  assign pending       = ctl.valid || ctl2_r.valid;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_lag_real  = out_re_r;
  assign out_lag_imag  = out_im_r;
  assign out_last_row  = out_last_r;

endmodule

FILE: hdl/wigner_ville_lag_product_unit.sv
// Channel     Ports                                        Transaction
// ----------  -------------------------------------------  -----------------------------
// input       start, busy, in_command, in_sample_*,        start & !busy at clk edge
//             in_time_instant
// result      out_valid, out_row_index, out_lag_real,      out_valid for one cycle
//             out_lag_imag, out_last_row
// config      cfg_we, cfg_index, cfg_data                  cfg_we at clk edge
//
// A load transaction writes the sample store in its accept cycle; busy stays low.
// A compute transaction issues one row per cycle from the store's two read ports;
// a column keeps busy high until its last row has left the multiply stage, and each row
// leaves through the store read, multiply and combine registers, in that order.
// Reset (rst_n low, synchronous) sets the registers to 1024 / 64 / complex and
// idles the sequencer; the sample store is not cleared.
// The receiver cannot stall: each row is shown for exactly one cycle.
module wigner_ville_lag_product_unit #(
  parameter int MAX_SAMPLES = wvlp_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = wvlp_pkg::DEF_SAMPLE_BITS,
  parameter int IDX_W       = $clog2(MAX_SAMPLES),
  parameter int LEN_W       = IDX_W + 1,
  parameter int CFG_W       = (LEN_W > wvlp_pkg::NF_W) ? LEN_W : wvlp_pkg::NF_W,
  parameter int OUT_W       = 2 * SAMPLE_BITS + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [IDX_W-1:0]               in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_real,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_imag,
  input  logic [LEN_W-1:0]               in_time_instant,
  // result channel
  output logic                           out_valid,
  output logic [wvlp_pkg::ROW_W-1:0]     out_row_index,
  output logic signed [OUT_W-1:0]        out_lag_real,
  output logic signed [OUT_W-1:0]        out_lag_imag,
  output logic                           out_last_row,
  // configuration
  input  logic                           cfg_we,
  input  logic [wvlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int NF_W = wvlp_pkg::NF_W;

  logic [LEN_W-1:0]   signal_length_r;
  logic [NF_W-1:0]    n_freq_r;
  logic               complex_mode_r;

  logic               accept, launch, load_we;
  logic               running, pending;
  logic [IDX_W-1:0]   raddr_a, raddr_b;
  logic [2*SAMPLE_BITS-1:0] rdata_a, rdata_b;
  wvlp_pkg::row_ctl_t ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signal_length_r <= LEN_W'(MAX_SAMPLES);
      n_freq_r        <= NF_W'(wvlp_pkg::MAX_BINS);
      complex_mode_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        wvlp_pkg::REG_SIGNAL_LENGTH: signal_length_r <= cfg_data[LEN_W-1:0];
        wvlp_pkg::REG_N_FREQ:        n_freq_r        <= cfg_data[NF_W-1:0];
        wvlp_pkg::REG_COMPLEX_MODE:  complex_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input transaction decode
  assign busy    = running || pending;
  assign accept  = start && !busy;
  assign launch  = accept && (in_command == wvlp_pkg::CMD_COMPUTE);
  assign load_we = accept && (in_command == wvlp_pkg::CMD_LOAD) &&
                   ({1'b0, in_sample_index} < (IDX_W + 1)'(MAX_SAMPLES));

  // Sample store
  wvlp_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .we      (load_we),
    .waddr   (in_sample_index),
    .wdata   ({in_sample_real, in_sample_imag}),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Row sequencer and address generation
  wvlp_addr_gen #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .IDX_W       (IDX_W),
    .LEN_W       (LEN_W)
  ) u_addr_gen (
    .clk           (clk),
    .rst_n         (rst_n),
    .launch        (launch),
    .time_instant  (in_time_instant),
    .signal_length (signal_length_r),
    .n_freq        (n_freq_r),
    .running       (running),
    .raddr_a       (raddr_a),
    .raddr_b       (raddr_b),
    .ctl           (ctl)
  );

  // Lag product pipeline
  wvlp_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_W       (OUT_W)
  ) u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .complex_mode  (complex_mode_r),
    .pending       (pending),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_lag_real  (out_lag_real),
    .out_lag_imag  (out_lag_imag),
    .out_last_row  (out_last_row)
  );

  // A column's last row is never followed directly by another row
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |=> !out_valid)
    else $error("row emitted right after last row");

  // Only a compute transaction makes the block busy
  a_busy_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_command == wvlp_pkg::CMD_COMPUTE))
    else $error("busy raised without a compute transaction");

  // The store is never written while a column is in flight
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (running || pending) |-> !load_we)
    else $error("store write during a column");

endmodule

FILE: tb/sv/tb_wigner_ville_lag_product_unit.sv
// One expected row of a lag-product column
typedef struct packed {
  logic [wvlp_pkg::ROW_W-1:0] row;
  logic [32:0]                re;
  logic [32:0]                im;
  logic                       last;
} lag_row_t;

// Tracks the register settings and sample store, predicts each column
// and checks the rows that come back in order.
class lag_row_scoreboard;
  localparam int STORE_DEPTH = wvlp_pkg::DEF_MAX_SAMPLES;

  logic [10:0]        sig_len;
  logic [6:0]         nfreq;
  logic               cplx;
  logic signed [15:0] store_re [STORE_DEPTH];
  logic signed [15:0] store_im [STORE_DEPTH];
  lag_row_t           pending_rows [$];
  int unsigned        errors;

  function new();
    sig_len = 11'd1024;
    nfreq   = 7'd64;
    cplx    = 1'b1;
    errors  = 0;
  endfunction

  function void write_reg(logic [wvlp_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
    case (idx)
      wvlp_pkg::REG_SIGNAL_LENGTH: sig_len = val;
      wvlp_pkg::REG_N_FREQ:        nfreq   = val[6:0];
      wvlp_pkg::REG_COMPLEX_MODE:  cplx    = val[0];
      default: ;
    endcase
  endfunction

  // Accepted transaction: loads update the store, computes queue a column
  function void note_item(logic cmd, logic [9:0] idx, logic signed [15:0] sre,
                          logic signed [15:0] sim, logic [10:0] t);
    int       len, nrows, half, p, taumax, lag, mag, a, b, r;
    longint   ra, rb, ia, ib, pr, pi;
    bit       use_row, real_only;
    lag_row_t e;
    if (cmd == wvlp_pkg::CMD_LOAD) begin
      store_re[idx] = sre;
      store_im[idx] = sim;
      return;
    end
    len   = (sig_len > STORE_DEPTH) ? STORE_DEPTH : int'(sig_len);
    nrows = (nfreq > wvlp_pkg::MAX_BINS) ? wvlp_pkg::MAX_BINS : int'(nfreq);
    half  = nrows / 2;
    p     = int'(t) - 1;
    // edge limit: nearest signal end or half the column
    taumax = p;
    if (len - p - 1 < taumax) taumax = len - p - 1;
    if (half - 1 < taumax) taumax = half - 1;
    for (r = 0; r < nrows; r++) begin
      lag       = (2 * r < nrows) ? r : r - nrows;
      mag       = (lag < 0) ? -lag : lag;
      use_row   = 1'b0;
      real_only = 1'b0;
      pr        = 0;
      pi        = 0;
      if (mag <= taumax) begin
        use_row = 1'b1;
      end else if (r == half && p >= half && p <= len - half - 1) begin
        // center row keeps only the real part of the half-column lag
        use_row   = 1'b1;
        real_only = 1'b1;
        lag       = half;
      end
      a = p + lag;
      b = p - lag;
      if (use_row && a >= 0 && b >= 0 && a < len && b < len) begin
        ra = store_re[a];
        rb = store_re[b];
        ia = store_im[a];
        ib = store_im[b];
        if (cplx) begin
          pr = ra * rb + ia * ib;
          pi = real_only ? 0 : ia * rb - ra * ib;
        end else begin
          pr = ra * rb;
        end
      end
      e.row  = r[wvlp_pkg::ROW_W-1:0];
      e.re   = pr[32:0];
      e.im   = pi[32:0];
      e.last = (r == nrows - 1);
      pending_rows.push_back(e);
    end
  endfunction

  // one line per mismatch, each one counted
  task report(string msg);
    errors++;
    $display("tb: mismatch: %s", msg);
  endtask

  task check_result(logic [wvlp_pkg::ROW_W-1:0] row, logic [32:0] re, logic [32:0] im,
                    logic last);
    lag_row_t e;
    if (pending_rows.size() == 0) begin
      report($sformatf("row %0d arrived with no column pending", row));
      return;
    end
    e = pending_rows.pop_front();
    if (row !== e.row)
      report($sformatf("row_index got %0d exp %0d", row, e.row));
    if (re !== e.re)
      report($sformatf("row %0d lag_real got %h exp %h", e.row, re, e.re));
    if (im !== e.im)
      report($sformatf("row %0d lag_imag got %h exp %h", e.row, im, e.im));
    if (last !== e.last)
      report($sformatf("row %0d last_row got %b exp %b", e.row, last, e.last));
  endtask
endclass

module tb_wigner_ville_lag_product_unit;

  localparam int STORE_DEPTH   = wvlp_pkg::DEF_MAX_SAMPLES;
  localparam int FILL_DEPTH    = 96;
  localparam int IDLE_LIMIT    = 600;
  localparam int SETTLE_CYCLES = 8;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_command;
  logic [9:0]                     in_sample_index;
  logic signed [15:0]             in_sample_real;
  logic signed [15:0]             in_sample_imag;
  logic [10:0]                    in_time_instant;
  logic                           out_valid;
  logic [wvlp_pkg::ROW_W-1:0]     out_row_index;
  logic signed [32:0]             out_lag_real;
  logic signed [32:0]             out_lag_imag;
  logic                           out_last_row;
  logic                           cfg_we;
  logic [wvlp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [10:0]                    cfg_data;

  lag_row_scoreboard sb;
  int                idle_cycles;
  int                burst_left;
  bit                steady;
  int                cur_len;

  wigner_ville_lag_product_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_sample_index (in_sample_index),
    .in_sample_real  (in_sample_real),
    .in_sample_imag  (in_sample_imag),
    .in_time_instant (in_time_instant),
    .out_valid       (out_valid),
    .out_row_index   (out_row_index),
    .out_lag_real    (out_lag_real),
    .out_lag_imag    (out_lag_imag),
    .out_last_row    (out_last_row),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_row_index, out_lag_real, out_lag_imag, out_last_row);
  end

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds the item until the block takes it
  task automatic send_item(logic cmd, logic [9:0] idx, logic signed [15:0] sre,
                           logic signed [15:0] sim, logic [10:0] t);
    start           <= 1'b1;
    in_command      <= cmd;
    in_sample_index <= idx;
    in_sample_real  <= sre;
    in_sample_imag  <= sim;
    in_time_instant <= t;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(cmd, idx, sre, sim, t);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender bursts with random gaps, unless in a steady stretch
  task automatic send_paced(logic cmd, logic [9:0] idx, logic signed [15:0] sre,
                            logic signed [15:0] sim, logic [10:0] t);
    if (!steady) begin
      if (burst_left == 0) begin
        pause($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    send_item(cmd, idx, sre, sim, t);
  endtask

  task automatic compute(logic [10:0] t);
    send_paced(wvlp_pkg::CMD_COMPUTE, 10'($urandom), 16'($urandom), 16'($urandom), t);
  endtask

  task automatic load(logic [9:0] idx, logic signed [15:0] sre, logic signed [15:0] sim);
    send_paced(wvlp_pkg::CMD_LOAD, idx, sre, sim, 11'($urandom));
  endtask

  // Wait until every expected row is out and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_rows.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [wvlp_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Full register setting; block must be idle
  task automatic apply_settings(logic [10:0] len, logic [6:0] nf, logic cm);
    drain();
    cfg_write(wvlp_pkg::REG_SIGNAL_LENGTH, len);
    cfg_write(wvlp_pkg::REG_N_FREQ, 11'(nf));
    cfg_write(wvlp_pkg::REG_COMPLEX_MODE, 11'(cm));
    cfg_we  <= 1'b0;
    cur_len = (len > STORE_DEPTH) ? STORE_DEPTH : int'(len);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Time instants mostly inside the signal, with edges and noise
  function automatic logic [10:0] rand_instant();
    int t;
    case ($urandom_range(0, 9))
      0:       t = $urandom_range(0, 2047);
      1:       t = $urandom_range(0, 40);
      2:       t = cur_len + 1 - $urandom_range(0, 40);
      default: t = $urandom_range(1, (cur_len > 0) ? cur_len : 1);
    endcase
    if (t < 0) t = 0;
    return 11'(t);
  endfunction

  // Main sequence
  initial begin
    logic [10:0] len;
    logic [6:0]  nf;
    sb = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command      <= wvlp_pkg::CMD_LOAD;
    in_sample_index <= '0;
    in_sample_real  <= '0;
    in_sample_imag  <= '0;
    in_time_instant <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= wvlp_pkg::REG_SIGNAL_LENGTH;
    cfg_data        <= '0;
    burst_left      = 0;
    steady          = 1'b0;
    cur_len         = STORE_DEPTH;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low part of the store; every column below reads only
    // that part or the top entry, which is loaded next
    for (int i = 0; i < FILL_DEPTH; i++) load(10'(i), rand_sample(), rand_sample());

    // directed: extreme samples, edge instants, out-of-range instants
    load(10'd0, 16'sh8000, 16'sh8000);
    load(10'd1023, 16'sh7fff, 16'sh7fff);
    load(10'd1, 16'sh7fff, 16'sh8000);
    load(10'd2, 16'sh8000, 16'sh7fff);
    compute(11'd1);
    compute(11'd2);
    compute(11'd33);
    compute(11'd1024);
    compute(11'd0);
    compute(11'd2047);
    compute(11'd1025);
    compute(11'd64);
    // single row: power of the sample itself
    apply_settings(11'd1024, 7'd1, 1'b1);
    compute(11'd1);
    compute(11'd1024);
    compute(11'd0);
    // zero rows: no result at all
    apply_settings(11'd1024, 7'd0, 1'b1);
    compute(11'd10);
    // row count above the limit, real mode
    apply_settings(11'd1024, 7'd127, 1'b0);
    compute(11'd40);
    compute(11'd1);
    // empty signal
    apply_settings(11'd0, 7'd64, 1'b1);
    compute(11'd1);
    // length above the store size, row count of two
    apply_settings(11'd2047, 7'd2, 1'b1);
    compute(11'd1024);
    compute(11'd1025);
    compute(11'd1);
    // one-sample signal
    apply_settings(11'd1, 7'd64, 1'b0);
    compute(11'd1);
    compute(11'd2);

    // random phases, each with its own setting; the signal stays in the filled part
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0:       len = 11'd1;
        1:       len = 11'(FILL_DEPTH);
        2:       len = 11'($urandom_range(1, 64));
        default: len = 11'($urandom_range(1, FILL_DEPTH));
      endcase
      case ($urandom_range(0, 5))
        0:       nf = 7'd2;
        1:       nf = 7'd64;
        2:       nf = 7'($urandom_range(0, 127));
        default: nf = 7'($urandom_range(2, 64));
      endcase
      if (ph == 0) begin
        len = 11'(FILL_DEPTH);
        nf  = 7'd64;
      end
      apply_settings(len, nf, 1'($urandom_range(0, 1)));
      steady     = (ph % 4 == 3);
      burst_left = 0;
      for (int k = 0; k < 19; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          load(10'($urandom_range(0, FILL_DEPTH - 1)), rand_sample(), rand_sample());
        end else begin
          // occasionally let the pipeline run dry mid-phase
          if ($urandom_range(0, 19) == 0) drain();
          compute(rand_instant());
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
